// ----- sv/bpfa_pkg.sv -----
`default_nettype none

package bpfa_pkg;

  // one map word covers this many frames
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = 6;

  // config port address width (two 32-bit registers)
  localparam int unsigned CFG_AW    = 3;

  // register index, taken from paddr[2]
  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_RSVD  = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_RANGE = 2'd2,
    ST_DFREE = 2'd3
  } status_e;

  // window limits applied to one map word during the search
  typedef struct packed {
    logic             lo_en;
    logic [BIT_W-1:0] lo_bit;
    logic             hi_en;
    logic [BIT_W-1:0] hi_bit;
  } scan_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] idx;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- sv/bpfa_ram.sv -----
`default_nettype none

module bpfa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/bpfa_word_scan.sv -----
`default_nettype none

module bpfa_word_scan import bpfa_pkg::*; (
  input  wire logic [WORD_BITS-1:0] word_i,
  input  wire scan_ctrl_t           ctrl_i,
  output scan_res_t                 res_o
);

  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  logic [WORD_BITS-1:0] free_bits;

  // free frames inside the window, then lowest index first
  always_comb begin
    free_bits = ~word_i;
    if (ctrl_i.lo_en) begin
      free_bits = free_bits & (ONES << ctrl_i.lo_bit);
    end
    if (ctrl_i.hi_en) begin
      free_bits = free_bits & (ONES >> (BIT_W'(WORD_BITS - 1) - ctrl_i.hi_bit));
    end
    res_o.hit = |free_bits;
    res_o.idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        res_o.idx = BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/bitmap_page_frame_allocator.sv -----
`default_nettype none
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------
// in       | in_valid_i / in_ready_o   | action_i, page_address_i
// out      | out_valid_o / out_ready_i | status_o, alloc_address_o, free_count_o
// config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// Steps, accept to out_valid_o: allocate reads one 64-frame word per cycle, from
// word 0 again on a wrap, then marks the frame; free reads, checks and writes, then
// gives the result; init writes all MAP_WORDS words; a full map or an out-of-range
// free goes straight to the result. in_ready_o rises with out_valid_o. Reset: a
// clearing pass writes all MAP_WORDS words (frame 0 used) before in_ready_o rises;
// config writes are taken meanwhile. Stalls: one transaction at a time; a result
// held in the output register only delays the end of the next transaction.

module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [31:0]       page_address_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [1:0]        status_o,
  output logic      [31:0]       alloc_address_o,
  output logic      [15:0]       free_count_o,
  // config port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int unsigned MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned WC_W      = WW + 1;
  localparam int unsigned FW        = $clog2(MAX_FRAMES);
  localparam int unsigned NW        = $clog2(MAX_FRAMES + 1);
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_AMARK = 8'b0000_1000,
    S_FRD   = 8'b0001_0000,
    S_FCHK  = 8'b0010_0000,
    S_INIT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [15:0]     total_q, rsvd_q;
  logic [15:0]     used_q, used_d;
  logic [FW-1:0]   start_q, start_d;
  logic [WC_W-1:0] wc_q, wc_d;
  logic [WW-1:0]   chk_w_q, chk_w_d;
  logic            chk_v_q, chk_v_d;
  logic            phase_q, phase_d;
  logic [FW-1:0]   lo_q, lo_d;
  logic [FW-1:0]   hl_q, hl_d;
  logic [FW-1:0]   frame_q, frame_d;
  logic [NW-1:0]   rinit_q, rinit_d;
  logic [WORD_BITS-1:0] wdata_q, wdata_d;
  status_e         res_status_q, res_status_d;
  logic [31:0]     res_addr_q, res_addr_d;

  logic            ovld_q;
  status_e         ostat_q;
  logic [31:0]     oaddr_q;
  logic [15:0]     ofree_q;

  logic [NW-1:0]   n_frames;
  logic [31:0]     n32, used32, fa32;
  logic [15:0]     free_cnt;
  logic            ss_ok;
  logic            in_fire, out_load;

  logic                 ram_we;
  logic [WW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic [WORD_BITS-1:0] init_word;

  logic [WW-1:0]   lo_w, hl_w, frame_w;
  logic [FW-1:0]   found_f;
  scan_ctrl_t      scan_ctrl;
  scan_res_t       scan_res;

  // managed frame count and free count
  assign n_frames = (32'(total_q) > MAX_FRAMES) ? NW'(MAX_FRAMES) : NW'(total_q);
  assign n32      = 32'(n_frames);
  assign used32   = 32'(used_q);
  assign free_cnt = (used32 >= n32) ? 16'd0 : 16'(n32 - used32);
  assign ss_ok    = 32'(start_q) < n32;
  assign fa32     = page_address_i >> PAGE_SHIFT;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!ovld_q || out_ready_i);

  // config registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_RSVD) ? 32'(rsvd_q) : 32'(total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 16'd32768;
      rsvd_q  <= 16'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == CFG_TOTAL) begin
        total_q <= pwdata[15:0];
      end else begin
        rsvd_q <= pwdata[15:0];
      end
    end
  end

  // word and bit positions
  assign lo_w    = WW'(lo_q >> BIT_W);
  assign hl_w    = WW'(hl_q >> BIT_W);
  assign frame_w = WW'(frame_q >> BIT_W);
  assign found_f = FW'({chk_w_q, scan_res.idx});

  assign scan_ctrl.lo_en  = (chk_w_q == lo_w);
  assign scan_ctrl.lo_bit = lo_q[BIT_W-1:0];
  assign scan_ctrl.hi_en  = (chk_w_q == hl_w);
  assign scan_ctrl.hi_bit = hl_q[BIT_W-1:0];

  bpfa_word_scan u_scan (
    .word_i (ram_rdata),
    .ctrl_i (scan_ctrl),
    .res_o  (scan_res)
  );

  // word written by the clearing pass and by init: frames below rinit used
  always_comb begin
    if (32'(wc_q) < 32'(rinit_q >> BIT_W)) begin
      init_word = ONES;
    end else if (32'(wc_q) == 32'(rinit_q >> BIT_W)) begin
      init_word = ~(ONES << rinit_q[BIT_W-1:0]);
    end else begin
      init_word = '0;
    end
  end

  // map RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = frame_w;
    ram_wdata = wdata_q;
    ram_raddr = frame_w;
    case (state_q)
      S_CLEAR, S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = wc_q[WW-1:0];
        ram_wdata = init_word;
      end
      S_SCAN: begin
        ram_raddr = wc_q[WW-1:0];
      end
      S_AMARK: begin
        ram_we = 1'b1;
      end
      S_FCHK: begin
        ram_we    = ram_rdata[frame_q[BIT_W-1:0]];
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << frame_q[BIT_W-1:0]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    start_d      = start_q;
    wc_d         = wc_q;
    chk_w_d      = chk_w_q;
    chk_v_d      = chk_v_q;
    phase_d      = phase_q;
    lo_d         = lo_q;
    hl_d         = hl_q;
    frame_d      = frame_q;
    rinit_d      = rinit_q;
    wdata_d      = wdata_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    case (state_q)
      S_CLEAR: begin
        if (wc_q == WC_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          wc_d = wc_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_OK;
          res_addr_d   = '0;
          case (action_i)
            ACT_ALLOC: begin
              if (used32 >= n32) begin
                res_status_d = ST_OOM;
                state_d      = S_DONE;
              end else begin
                lo_d    = ss_ok ? start_q : '0;
                hl_d    = FW'(n32 - 32'd1);
                wc_d    = WC_W'(lo_d >> BIT_W);
                chk_v_d = 1'b0;
                phase_d = 1'b0;
                state_d = S_SCAN;
              end
            end
            ACT_FREE: begin
              if (fa32 >= n32) begin
                res_status_d = ST_RANGE;
                state_d      = S_DONE;
              end else begin
                frame_d = FW'(fa32);
                state_d = S_FRD;
              end
            end
            ACT_INIT: begin
              rinit_d = (32'(rsvd_q) < n32) ? NW'(rsvd_q) : n_frames;
              wc_d    = '0;
              state_d = S_INIT;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue the next word read while checking the previous one
        wc_d    = wc_q + 1'b1;
        chk_w_d = wc_q[WW-1:0];
        chk_v_d = 1'b1;
        if (chk_v_q) begin
          if (scan_res.hit) begin
            frame_d = found_f;
            wdata_d = ram_rdata | (WORD_BITS'(1) << scan_res.idx);
            state_d = S_AMARK;
          end else if (chk_w_q == hl_w) begin
            if (!phase_q && (lo_q != '0)) begin
              // wrap: search frames below the old start
              phase_d = 1'b1;
              hl_d    = lo_q - 1'b1;
              lo_d    = '0;
              wc_d    = '0;
              chk_v_d = 1'b0;
            end else begin
              res_status_d = ST_OOM;
              state_d      = S_DONE;
            end
          end
        end
      end
      S_AMARK: begin
        used_d       = (used_q != 16'hFFFF) ? used_q + 1'b1 : used_q;
        start_d      = frame_q + 1'b1;
        res_status_d = ST_OK;
        res_addr_d   = 32'(64'(frame_q) << PAGE_SHIFT);
        state_d      = S_DONE;
      end
      S_FRD: begin
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (ram_rdata[frame_q[BIT_W-1:0]]) begin
          used_d       = (used_q != 16'd0) ? used_q - 1'b1 : used_q;
          res_status_d = ST_OK;
        end else begin
          res_status_d = ST_DFREE;
        end
        state_d = S_DONE;
      end
      S_INIT: begin
        if (wc_q == WC_W'(MAP_WORDS - 1)) begin
          used_d       = 16'(rinit_q);
          start_d      = '0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end else begin
          wc_d = wc_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      used_q  <= 16'd1;
      start_q <= '0;
      wc_q    <= '0;
      chk_v_q <= 1'b0;
      phase_q <= 1'b0;
      rinit_q <= NW'(1);
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      start_q <= start_d;
      wc_q    <= wc_d;
      chk_v_q <= chk_v_d;
      phase_q <= phase_d;
      rinit_q <= rinit_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    chk_w_q      <= chk_w_d;
    lo_q         <= lo_d;
    hl_q         <= hl_d;
    frame_q      <= frame_d;
    wdata_q      <= wdata_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (out_load) begin
      ovld_q <= 1'b1;
    end else if (out_ready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ostat_q <= res_status_q;
      oaddr_q <= res_addr_q;
      ofree_q <= free_cnt;
    end
  end

  assign out_valid_o     = ovld_q;
  assign status_o        = ostat_q;
  assign alloc_address_o = oaddr_q;
  assign free_count_o    = ofree_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken again while a transaction is in work");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && chk_v_q && scan_res.hit) |-> (32'(found_f) < n32))
    else $error("search hit beyond managed frames");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !ram_we)
    else $error("map written outside an action");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_bitmap_page_frame_allocator.sv -----
`default_nettype none

module tb_bitmap_page_frame_allocator;
  import bpfa_pkg::*;

  localparam int unsigned MAX_FRAMES = 32768;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam logic [31:0] PAGE_MASK  = (32'd1 << PAGE_SHIFT) - 32'd1;

  // action code the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // random phases: frame count and reserved count per phase
  localparam int unsigned NUM_PHASES = 9;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned PHASE_TOTAL [NUM_PHASES] =
    '{64, 200, 1, 65535, 1000, 32768, 0, 130, 20};
  localparam int unsigned PHASE_RSVD [NUM_PHASES] =
    '{3, 70, 0, 65535, 0, 1, 5, 129, 0};

  typedef struct {
    status_e     status;
    logic [31:0] addr;
    logic [15:0] free_cnt;
  } reply_t;

  // Mirror of the frame map, next-fit pointer and used count; computes the
  // reply to each request and holds the replies still owed by the block.
  class frame_alloc_tracker;
    bit          used [MAX_FRAMES];
    int unsigned next_fit;
    int unsigned used_cnt;
    int unsigned total_pg;
    int unsigned rsvd_pg;
    reply_t      replies_due [$];
    int unsigned mismatches;

    function new();
      used        = '{default: 1'b0};
      used[0]     = 1'b1;
      next_fit    = 0;
      used_cnt    = 1;
      total_pg    = 32768;
      rsvd_pg     = 1;
      mismatches  = 0;
    endfunction

    function void set_register(logic idx, logic [15:0] val);
      if (idx == CFG_TOTAL) begin
        total_pg = val;
      end else begin
        rsvd_pg = val;
      end
    endfunction

    function int unsigned frames();
      return (total_pg > MAX_FRAMES) ? MAX_FRAMES : total_pg;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function reply_t take_request(logic [1:0] act, logic [31:0] addr);
      reply_t      r;
      int unsigned n, start, f, i, lim;
      bit          found;
      n          = frames();
      r.status   = ST_OK;
      r.addr     = '0;
      found      = 1'b0;
      f          = 0;
      case (act)
        ACT_ALLOC: begin
          // next fit: from the pointer up, then wrap to frame 0
          start = (next_fit < n) ? next_fit : 0;
          if (used_cnt < n) begin
            for (i = 0; i < n; i++) begin
              f = start + i;
              if (f >= n) f -= n;
              if (!used[f]) begin
                found = 1'b1;
                break;
              end
            end
          end
          if (found) begin
            used[f] = 1'b1;
            if (used_cnt < 65535) used_cnt++;
            next_fit = f + 1;
            r.addr   = 32'(f) << PAGE_SHIFT;
          end else begin
            r.status = ST_OOM;
          end
        end
        ACT_FREE: begin
          f = addr >> PAGE_SHIFT;
          if (f >= n) begin
            r.status = ST_RANGE;
          end else if (!used[f]) begin
            r.status = ST_DFREE;
          end else begin
            used[f] = 1'b0;
            if (used_cnt > 0) used_cnt--;
          end
        end
        ACT_INIT: begin
          lim  = (rsvd_pg < n) ? rsvd_pg : n;
          used = '{default: 1'b0};
          for (i = 0; i < lim; i++) used[i] = 1'b1;
          used_cnt = lim;
          next_fit = 0;
        end
        default: begin
          // unused code: no state change
        end
      endcase
      r.free_cnt = (used_cnt >= n) ? 16'd0 : 16'(n - used_cnt);
      replies_due.push_back(r);
      return r;
    endfunction

    function void compare_reply(logic [1:0] st, logic [31:0] addr, logic [15:0] fc);
      reply_t e;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result: status %0d addr %h free %0d",
                 $time, st, addr, fc);
        mismatches++;
        return;
      end
      e = replies_due.pop_front();
      if (st !== e.status) begin
        $display("%0t: status: expected %0d, actual %0d", $time, e.status, st);
        mismatches++;
      end
      if (addr !== e.addr) begin
        $display("%0t: alloc_address: expected %h, actual %h", $time, e.addr, addr);
        mismatches++;
      end
      if (fc !== e.free_cnt) begin
        $display("%0t: free_count: expected %0d, actual %0d", $time, e.free_cnt, fc);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        action_i;
  logic [31:0]       page_address_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [31:0]       alloc_address_o;
  logic [15:0]       free_count_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  frame_alloc_tracker tracker = new();

  bitmap_page_frame_allocator #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .page_address_i  (page_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o),
    .free_count_o    (free_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("tb_bitmap_page_frame_allocator: done, errors");
    $finish;
  end

  // result monitor: every accepted result is checked against the oldest owed reply
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.compare_reply(status_o, alloc_address_o, free_count_o);
    end
  end

  // receiver: random stall before each result, with stretches of no stalls
  initial begin
    int unsigned stall;
    bit          burst_out;
    burst_out   = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) burst_out = !burst_out;
      stall = burst_out ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  bit burst_in = 1'b0;

  // one request transaction; returns the reply the block owes for it
  task automatic send_request(input logic [1:0] act, input logic [31:0] addr,
                              output reply_t due);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) burst_in = !burst_in;
    gap = burst_in ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    page_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    due = tracker.take_request(act, addr);
  endtask

  // stop sending and wait until every owed reply has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write followed by a read-back
  task automatic write_reg(input logic idx, input logic [15:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_register(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {16'h0, val}) begin
      $display("%0t: register %0d read: expected %h, actual %h",
               $time, idx, {16'h0, val}, rd);
      tracker.mismatches++;
    end
  endtask

  initial begin
    reply_t      due;
    logic [31:0] held_frames [$];
    logic [31:0] last_freed;
    logic [31:0] a;
    int unsigned p, k, pick, idx, n_cur;

    last_freed     = 32'h0000_1000;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_ALLOC;
    page_address_i <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rst_ni         <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: state after reset, frame 0 used
    send_request(ACT_ALLOC,  32'h0000_0000, due);
    send_request(ACT_ALLOC,  32'hFFFF_FFFF, due);
    send_request(ACT_FREE,   32'h0000_1FFF, due);  // low bits ignored
    send_request(ACT_FREE,   32'h0000_1000, due);  // double free
    send_request(ACT_FREE,   32'hFFFF_FFFF, due);  // far out of range
    send_request(ACT_FREE,   32'h0800_0000, due);  // first frame past the end
    send_request(ACT_FREE,   32'h07FF_F000, due);  // last frame, never used
    send_request(ACT_UNUSED, 32'hFFFF_FFFF, due);
    send_request(ACT_FREE,   32'h0000_0000, due);
    send_request(ACT_INIT,   32'h0000_0000, due);

    // single frame, nothing reserved; pointer goes stale after each allocate
    settle();
    write_reg(CFG_TOTAL, 16'd1);
    write_reg(CFG_RSVD,  16'd0);
    send_request(ACT_INIT,  32'h0000_0000, due);
    send_request(ACT_ALLOC, 32'h0000_0000, due);
    send_request(ACT_ALLOC, 32'h0000_0000, due);  // out of memory
    send_request(ACT_FREE,  32'h0000_1000, due);  // out of range
    send_request(ACT_FREE,  32'h0000_0FFF, due);
    send_request(ACT_ALLOC, 32'h0000_0000, due);

    // frame count above the maximum, reserved covers everything
    settle();
    write_reg(CFG_TOTAL, 16'hFFFF);
    write_reg(CFG_RSVD,  16'hFFFF);
    send_request(ACT_INIT,  32'h0000_0000, due);
    send_request(ACT_ALLOC, 32'h0000_0000, due);
    send_request(ACT_FREE,  32'h07FF_F000, due);
    send_request(ACT_ALLOC, 32'h0000_0000, due);  // full scan up to the last frame

    // shrink without init: count above the new frame count
    settle();
    write_reg(CFG_TOTAL, 16'd16);
    send_request(ACT_ALLOC, 32'h0000_0000, due);
    send_request(ACT_FREE,  32'h0001_0000, due);

    // no frames at all
    settle();
    write_reg(CFG_TOTAL, 16'd0);
    write_reg(CFG_RSVD,  16'd0);
    send_request(ACT_ALLOC, 32'h0000_0000, due);
    send_request(ACT_FREE,  32'h0000_0000, due);
    send_request(ACT_INIT,  32'h0000_0000, due);

    // random phases: mostly allocate/free of live frames, some noise
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_TOTAL, 16'(PHASE_TOTAL[p]));
      write_reg(CFG_RSVD,  16'(PHASE_RSVD[p]));
      if ($urandom_range(0, 3) != 0) begin
        send_request(ACT_INIT, $urandom, due);
        held_frames.delete();
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // hold off mid-phase until the block has caught up
        if (p == 4 && k == PHASE_ITEMS / 2) settle();
        pick  = $urandom_range(0, 99);
        n_cur = tracker.frames();
        if (pick < 45) begin
          send_request(ACT_ALLOC, $urandom, due);
          if (due.status == ST_OK) held_frames.push_back(due.addr);
        end else if (pick < 75 && held_frames.size() > 0) begin
          idx = $urandom_range(0, held_frames.size() - 1);
          a   = held_frames[idx] | ($urandom & PAGE_MASK);
          held_frames.delete(idx);
          send_request(ACT_FREE, a, due);
          last_freed = a;
        end else if (pick < 80) begin
          send_request(ACT_FREE, last_freed, due);
        end else if (pick < 88) begin
          if (n_cur > 0) begin
            a = (32'($urandom_range(0, n_cur - 1)) << PAGE_SHIFT) | ($urandom & PAGE_MASK);
          end else begin
            a = $urandom;
          end
          send_request(ACT_FREE, a, due);
        end else if (pick < 95) begin
          send_request(ACT_FREE, $urandom, due);
        end else if (pick < 98) begin
          send_request(ACT_INIT, $urandom, due);
          held_frames.delete();
        end else begin
          send_request(ACT_UNUSED, $urandom, due);
        end
      end
    end

    // drain and let any late activity show up
    settle();
    repeat (600) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_bitmap_page_frame_allocator: done, clean");
    end else begin
      $display("tb_bitmap_page_frame_allocator: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
